/* sv/bsa_pkg.sv */
`default_nettype none

package bsa_pkg;

   localparam int NUM_PROCESSES = 5;
   localparam int NUM_RESOURCES = 3;
   localparam int UNIT_WIDTH    = 8;

   // resource types carried by the registers and input fields
   localparam int FIELD_RES      = 3;
   localparam int OP_WIDTH       = 2;
   localparam int PROCESS_WIDTH  = 3;
   localparam int AMOUNT_WIDTH   = 8;
   localparam int TOTAL_WIDTH    = 8;
   localparam int STATUS_WIDTH   = 2;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_IDX_WIDTH  = CSR_ADDR_WIDTH - 2;

   localparam int PROC_IDX_WIDTH = $clog2(NUM_PROCESSES);
   // avail plus every held count, the tentative row up to twice a unit
   localparam int WORK_WIDTH     = UNIT_WIDTH + $clog2(2 * NUM_PROCESSES + 1);

   localparam logic [OP_WIDTH-1:0] OP_INIT    = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_LOAD    = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_REQUEST = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED  = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] STAT_OK          = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_OVER_NEED   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_OVER_AVAIL  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STAT_UNSAFE      = 2'd3;

   localparam logic [REG_IDX_WIDTH-1:0] REG_TOTAL_RES0 = 2'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_TOTAL_RES1 = 2'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_TOTAL_RES2 = 2'd2;

   typedef logic [UNIT_WIDTH-1:0]     unit_type;
   typedef logic [UNIT_WIDTH:0]       wide_unit_type;
   typedef logic [WORK_WIDTH-1:0]     work_type;
   typedef logic [PROC_IDX_WIDTH-1:0] proc_idx_type;

   typedef unit_type      [NUM_RESOURCES-1:0] row_type;
   typedef wide_unit_type [NUM_RESOURCES-1:0] wide_row_type;
   typedef work_type      [NUM_RESOURCES-1:0] work_row_type;

   typedef logic [FIELD_RES-1:0][TOTAL_WIDTH-1:0]  totals_type;
   typedef logic [FIELD_RES-1:0][AMOUNT_WIDTH-1:0] amounts_type;

   typedef struct packed {
      logic capture;
      logic do_init;
      logic do_load;
      logic search_start;
      logic search_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic                in_range;
      logic                over_need;
      logic                over_avail;
      logic                search_done;
      logic                search_safe;
   } stat_type;

endpackage

`default_nettype wire

/* sv/bsa_intf.sv */
`default_nettype none

interface bsa_req_if import bsa_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_WIDTH-1:0]      operation;
   logic [PROCESS_WIDTH-1:0] process;
   logic [AMOUNT_WIDTH-1:0]  amount_res0;
   logic [AMOUNT_WIDTH-1:0]  amount_res1;
   logic [AMOUNT_WIDTH-1:0]  amount_res2;

   modport source (output valid, operation, process, amount_res0, amount_res1, amount_res2,
                   input ready);
   modport sink (input valid, operation, process, amount_res0, amount_res1, amount_res2,
                 output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    granted;
   logic [STATUS_WIDTH-1:0] status;

   modport source (output valid, granted, status, input ready);
   modport sink (input valid, granted, status, output ready);
endinterface

`default_nettype wire

/* sv/bsa_csr.sv */
`default_nettype none

module bsa_csr import bsa_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready,
   output totals_type                     totals
);

   totals_type               total_ff;
   totals_type               total_in;
   logic                     wr_en;
   logic [REG_IDX_WIDTH-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_WIDTH-1:2];
   assign totals  = total_ff;

   always_comb begin
      total_in = total_ff;
      prdata   = '0;
      unique case (reg_idx)
         REG_TOTAL_RES0: begin
            if (wr_en) total_in[0] = pwdata[TOTAL_WIDTH-1:0];
            prdata = CSR_DATA_WIDTH'(total_ff[0]);
         end
         REG_TOTAL_RES1: begin
            if (wr_en) total_in[1] = pwdata[TOTAL_WIDTH-1:0];
            prdata = CSR_DATA_WIDTH'(total_ff[1]);
         end
         REG_TOTAL_RES2: begin
            if (wr_en) total_in[2] = pwdata[TOTAL_WIDTH-1:0];
            prdata = CSR_DATA_WIDTH'(total_ff[2]);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

endmodule

`default_nettype wire

/* sv/bsa_ctrl.sv */
`default_nettype none

module bsa_ctrl import bsa_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_granted,
   output logic     [STATUS_WIDTH-1:0]   rsp_status,
   output cmd_type                       cmd,
   input  wire stat_type                 st
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CHECK  = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic                    pend_granted_ff, pend_granted_in;
   logic [STATUS_WIDTH-1:0] pend_status_ff, pend_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_granted_ff, rsp_granted_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_status  = rsp_status_ff;

   always_comb begin
      cmd             = '0;
      state_in        = state_ff;
      pend_granted_in = pend_granted_ff;
      pend_status_in  = pend_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_granted_in  = rsp_granted_ff;
      rsp_status_in   = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in        = S_FINISH;
            pend_granted_in = 1'b0;
            pend_status_in  = STAT_OK;
            unique case (st.op)
               OP_INIT: begin
                  cmd.do_init     = 1'b1;
                  pend_granted_in = 1'b1;
               end
               OP_LOAD: begin
                  if (st.in_range) begin
                     cmd.do_load     = 1'b1;
                     pend_granted_in = 1'b1;
                  end else begin
                     pend_status_in = STAT_OVER_NEED;
                  end
               end
               OP_REQUEST: begin
                  if (!st.in_range || st.over_need) begin
                     pend_status_in = STAT_OVER_NEED;
                  end else if (st.over_avail) begin
                     pend_status_in = STAT_OVER_AVAIL;
                  end else begin
                     cmd.search_start = 1'b1;
                     state_in         = S_SEARCH;
                  end
               end
               OP_UNUSED: begin
               end
               default: begin
               end
            endcase
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (st.search_done) begin
               state_in = S_FINISH;
               if (st.search_safe) begin
                  cmd.commit      = 1'b1;
                  pend_granted_in = 1'b1;
                  pend_status_in  = STAT_OK;
               end else begin
                  pend_granted_in = 1'b0;
                  pend_status_in  = STAT_UNSAFE;
               end
            end
         end
         S_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = pend_granted_ff;
               rsp_status_in  = pend_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_granted_ff <= pend_granted_in;
      pend_status_ff  <= pend_status_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_status_ff   <= rsp_status_in;
   end

endmodule

`default_nettype wire

/* sv/bsa_dpath.sv */
`default_nettype none

module bsa_dpath import bsa_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [OP_WIDTH-1:0]      operation,
   input  wire logic [PROCESS_WIDTH-1:0] process,
   input  wire amounts_type              amounts,
   input  wire totals_type               totals,
   input  wire cmd_type                  cmd,
   output stat_type                      st
);

   row_type [NUM_PROCESSES-1:0] held_ff, held_in;
   row_type [NUM_PROCESSES-1:0] need_ff, need_in;
   row_type                     avail_ff, avail_in;

   logic [OP_WIDTH-1:0]      op_ff;
   logic [PROCESS_WIDTH-1:0] proc_ff;
   row_type                  amt_ff;
   row_type                  amt_sel;
   row_type                  total_sel;

   wide_row_type             tent_held_ff, tent_held_in;
   row_type                  tent_need_ff, tent_need_in;
   work_row_type             work_ff, work_in;
   work_row_type             work_add;
   logic [NUM_PROCESSES-1:0] done_ff, done_in, done_next;
   logic                     progress_ff, progress_in, progress_next;
   proc_idx_type             row_ff, row_in;

   logic         in_range;
   proc_idx_type proc_idx;
   proc_idx_type row_sel;
   row_type      rd_held, rd_need;
   row_type      eff_need;
   wide_row_type eff_held;
   logic         is_proc_row;
   logic         fits, take, last_row;
   logic         over_need, over_avail;

   // resource types past the field count read as zero
   for (genvar r = 0; r < NUM_RESOURCES; r++) begin : g_res
      if (r < FIELD_RES) begin : g_field
         assign amt_sel[r]   = UNIT_WIDTH'(amounts[r]);
         assign total_sel[r] = UNIT_WIDTH'(totals[r]);
      end else begin : g_zero
         assign amt_sel[r]   = '0;
         assign total_sel[r] = '0;
      end
   end

   assign in_range = (32'(proc_ff) < 32'(NUM_PROCESSES));
   assign proc_idx = in_range ? PROC_IDX_WIDTH'(proc_ff) : '0;
   assign row_sel  = cmd.search_step ? row_ff : proc_idx;
   assign rd_held  = held_ff[row_sel];
   assign rd_need  = need_ff[row_sel];

   assign is_proc_row = (row_ff == proc_idx);
   assign last_row    = (row_ff == PROC_IDX_WIDTH'(NUM_PROCESSES - 1));

   always_comb begin
      over_need  = 1'b0;
      over_avail = 1'b0;
      fits       = 1'b1;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         if (amt_ff[r] > rd_need[r]) over_need = 1'b1;
         if (amt_ff[r] > avail_ff[r]) over_avail = 1'b1;
         // the requesting process is seen with its tentative row
         eff_need[r] = is_proc_row ? tent_need_ff[r] : rd_need[r];
         eff_held[r] = is_proc_row ? tent_held_ff[r] : {1'b0, rd_held[r]};
         if (WORK_WIDTH'(eff_need[r]) > work_ff[r]) fits = 1'b0;
         work_add[r] = work_ff[r] + WORK_WIDTH'(eff_held[r]);
      end
      take               = !done_ff[row_ff] && fits;
      done_next          = done_ff;
      done_next[row_ff]  = done_ff[row_ff] | take;
      progress_next      = progress_ff | take;
   end

   always_comb begin
      st.op          = op_ff;
      st.in_range    = in_range;
      st.over_need   = over_need;
      st.over_avail  = over_avail;
      // a pass with no progress ends the search, as does all done
      st.search_done = last_row && ((&done_next) || !progress_next);
      st.search_safe = &done_next;
   end

   always_comb begin
      avail_in     = avail_ff;
      held_in      = held_ff;
      need_in      = need_ff;
      tent_held_in = tent_held_ff;
      tent_need_in = tent_need_ff;
      work_in      = work_ff;
      done_in      = done_ff;
      progress_in  = progress_ff;
      row_in       = row_ff;

      if (cmd.do_init) begin
         avail_in = total_sel;
         held_in  = '0;
         need_in  = '0;
      end
      if (cmd.do_load) begin
         need_in[proc_idx] = amt_ff;
      end
      if (cmd.search_start) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            work_in[r]      = WORK_WIDTH'(avail_ff[r] - amt_ff[r]);
            tent_held_in[r] = {1'b0, rd_held[r]} + {1'b0, amt_ff[r]};
            tent_need_in[r] = rd_need[r] - amt_ff[r];
         end
         done_in     = '0;
         progress_in = 1'b0;
         row_in      = '0;
      end
      if (cmd.search_step) begin
         if (take) work_in = work_add;
         done_in = done_next;
         if (last_row) begin
            row_in      = '0;
            progress_in = 1'b0;
         end else begin
            row_in      = row_ff + 1'b1;
            progress_in = progress_next;
         end
      end
      if (cmd.commit) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            avail_in[r]          = avail_ff[r] - amt_ff[r];
            held_in[proc_idx][r] = tent_held_ff[r][UNIT_WIDTH-1:0];
            need_in[proc_idx][r] = tent_need_ff[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff    <= '0;
         held_ff     <= '0;
         need_ff     <= '0;
         done_ff     <= '0;
         progress_ff <= 1'b0;
         row_ff      <= '0;
      end else begin
         avail_ff    <= avail_in;
         held_ff     <= held_in;
         need_ff     <= need_in;
         done_ff     <= done_in;
         progress_ff <= progress_in;
         row_ff      <= row_in;
      end
      if (cmd.capture) begin
         op_ff   <= operation;
         proc_ff <= process;
         amt_ff  <= amt_sel;
      end
      tent_held_ff <= tent_held_in;
      tent_need_ff <= tent_need_in;
      work_ff      <= work_in;
   end

endmodule

`default_nettype wire

/* sv/bankers_safe_allocation_core.sv */
// Init, load and unused-code items: captured on accept, checked in S_CHECK, result registered
// from S_FINISH. Requests: after S_CHECK the safety search steps one process row a cycle in
// S_SEARCH, in passes over all rows, at most NUM_PROCESSES passes, before S_FINISH registers
// the result. One item in flight; the next item is taken while the result waits in the
// output register, and a result not yet taken stalls the next one.
// Reset (synchronous, active high) clears totals, available counts, allocations and needs.
`default_nettype none

module bankers_safe_allocation_core import bsa_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bsa_req_if.sink                        req_if,
   bsa_rsp_if.source                      rsp_if,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   totals_type  totals;
   amounts_type amounts;
   cmd_type     cmd;
   stat_type    st;
   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_granted;
   logic [STATUS_WIDTH-1:0] rsp_status;

   assign amounts        = {req_if.amount_res2, req_if.amount_res1, req_if.amount_res0};
   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.granted = rsp_granted;
   assign rsp_if.status  = rsp_status;

   bsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .totals  (totals)
   );

   bsa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_granted (rsp_granted),
      .rsp_status  (rsp_status),
      .cmd         (cmd),
      .st          (st)
   );

   bsa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .operation (req_if.operation),
      .process   (req_if.process),
      .amounts   (amounts),
      .totals    (totals),
      .cmd       (cmd),
      .st        (st)
   );

   // a commit only ends a safe search and never coincides with an init or load
   a_commit_safe: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (st.search_done && st.search_safe && !cmd.do_init && !cmd.do_load))
      else $error("commit outside a safe search end");

   // an accepted item blocks further items until its result is registered
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (!req_if.ready && !cmd.commit))
      else $error("item accepted while another is in flight");

   // after a commit the block registers its result before taking another item
   a_commit_then_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !req_if.ready)
      else $error("item taken straight after commit");

   // the search never starts for a refused request: out-of-range process, over need or over avail
   a_search_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.search_start |-> (st.in_range && !st.over_need && !st.over_avail))
      else $error("search started for a refused request");

endmodule

`default_nettype wire
